[design/wbps_pkg.sv]
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the masked byte signature scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

    // Fixed field widths of the register file and the beats
    localparam int CFG_DATA_W  = 64;
    localparam int SIG_BYTES   = 16;
    localparam int SIG_SEL_W   = $clog2(SIG_BYTES);
    localparam int CARE_W      = 16;
    localparam int LENGTH_W    = 5;
    localparam int OFFSET_W    = 32;
    localparam int REG_INDEX_W = 2;

    // Register indexes
    localparam logic [REG_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [REG_INDEX_W-1:0] REG_CARE_MASK    = 2'd2;
    localparam logic [REG_INDEX_W-1:0] REG_PATTERN_LEN  = 2'd3;

    // Register reset values
    localparam logic [CARE_W-1:0]   CARE_MASK_RESET  = 16'hFFFF;
    localparam logic [LENGTH_W-1:0] PATTERN_LEN_RESET = 5'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } item_beat_t;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
    } result_beat_t;

    // Per-cell compare reference, driven by the top level
    typedef struct packed {
        logic       in_use;
        logic       care;
        logic [7:0] sig;
    } cell_ref_t;

endpackage

`default_nettype wire

[design/wbps_cell.sv]
// ----------------------------------------------------------------------------
// wbps_cell
// One window cell: holds one byte of the sliding window and checks the byte
// it is about to take against its signature byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cell
    import wbps_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       shift,
    input  wire logic [7:0] byte_in,
    input  wire cell_ref_t  cmp_ref,
    output logic [7:0]      byte_out,
    output logic            hit
);

    logic [7:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;
    // unused position or wildcard always passes
    assign hit = !cmp_ref.in_use || !cmp_ref.care || (byte_in == cmp_ref.sig);

endmodule

`default_nettype wire

[design/wbps_out_buf.sv]
// ----------------------------------------------------------------------------
// wbps_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_out_buf
    import wbps_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire result_beat_t  push_beat,
    input  wire logic          out_ready,
    output logic               out_valid,
    output result_beat_t       out_beat,
    output logic               full
);

    logic         head_valid_reg;
    logic         head_valid_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    result_beat_t head_reg;
    result_beat_t skid_reg;
    logic         pop;

    assign pop = head_valid_reg && out_ready;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            head_valid_next = skid_valid_reg || push;
            skid_valid_next = skid_valid_reg && push;
        end
        else if (push)
        begin
            head_valid_next = 1'b1;
            skid_valid_next = head_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload moves; no reset needed
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
                if (push)
                begin
                    skid_reg <= push_beat;
                end
            end
            else if (push)
            begin
                head_reg <= push_beat;
            end
        end
        else if (push)
        begin
            if (head_valid_reg)
            begin
                skid_reg <= push_beat;
            end
            else
            begin
                head_reg <= push_beat;
            end
        end
    end

    assign out_valid = head_valid_reg;
    assign out_beat  = head_reg;
    assign full      = skid_valid_reg;

endmodule

`default_nettype wire

[design/wildcard_byte_pattern_scan.sv]
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Scans a byte stream for the first match of a masked signature of up to
// MAX_PATTERN bytes and reports its start offset, or not-found, once per region.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                  | beat
//  ---------+------------------------------------------+-------------------------
//  item     | item_valid, item_ready, item             | one region byte + last
//  result   | result_valid, result_ready, result       | found + match_offset
//  config   | cfg_write, cfg_index, cfg_data           | one register write
//
//  - One byte per cycle while item_ready is high; the result a byte causes is
//    registered into the output (or skid) register when that byte is taken.
//  - The window compare is done by a row of cells, all in the accept cycle.
//  - item_ready drops only when the output register and the skid register
//    both hold a result that has not been taken.
//  - rst_n is asynchronous, active low; it clears counters, flags and the
//    registers to their reset values. Window bytes are not cleared (the
//    fill count gates every compare).
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_scan
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration
    input  wire logic                   cfg_write,
    input  wire logic [REG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // byte stream
    input  wire logic                   item_valid,
    output logic                        item_ready,
    input  wire item_beat_t             item,
    // results
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output result_beat_t                result
);

    localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);
    localparam int WIDE_W   = (OFFSET_BITS > OFFSET_W) ? OFFSET_BITS : OFFSET_W;

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [CARE_W-1:0]     care_mask_reg;
    logic [LENGTH_W-1:0]   pattern_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            care_mask_reg    <= CARE_MASK_RESET;
            pattern_len_reg  <= PATTERN_LEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                REG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                REG_CARE_MASK:    care_mask_reg    <= cfg_data[CARE_W-1:0];
                REG_PATTERN_LEN:  pattern_len_reg  <= cfg_data[LENGTH_W-1:0];
                default:          pattern_low_reg  <= pattern_low_reg;
            endcase
        end
    end

    // Effective length: 0 reads as 1, anything above MAX_PATTERN clamps
    logic [LEN_BITS-1:0] len_used;

    always_comb
    begin
        if (pattern_len_reg == '0)
        begin
            len_used = LEN_BITS'(1);
        end
        else if (pattern_len_reg > LENGTH_W'(MAX_PATTERN))
        begin
            len_used = LEN_BITS'(MAX_PATTERN);
        end
        else
        begin
            len_used = LEN_BITS'(pattern_len_reg);
        end
    end

    logic [8*SIG_BYTES-1:0] pattern_bits;
    assign pattern_bits = {pattern_high_reg, pattern_low_reg};

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic buf_full;
    logic item_fire;

    assign item_ready = !buf_full;
    assign item_fire  = item_valid && item_ready;

    // ------------------------------------------------------------------
    // Window cell row. Cell k takes the byte that will sit k beats back
    // after this shift and checks it against signature byte len-1-k.
    // ------------------------------------------------------------------
    logic [7:0]             chain [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_hit;

    assign chain[0] = item.data_byte;

    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        logic [SIG_SEL_W-1:0] sel;
        cell_ref_t            cmp_ref;

        assign sel            = SIG_SEL_W'(int'(len_used) - 1 - k);
        assign cmp_ref.in_use = LEN_BITS'(k) < len_used;
        assign cmp_ref.care   = care_mask_reg[sel];
        assign cmp_ref.sig    = pattern_bits[8*sel +: 8];

        if (k < MAX_PATTERN - 1)
        begin : g_mid
            wbps_cell u_cell (
                .clk      (clk),
                .shift    (item_fire),
                .byte_in  (chain[k]),
                .cmp_ref  (cmp_ref),
                .byte_out (chain[k+1]),
                .hit      (cell_hit[k])
            );
        end
        else
        begin : g_end
            wbps_cell u_cell (
                .clk      (clk),
                .shift    (item_fire),
                .byte_in  (chain[k]),
                .cmp_ref  (cmp_ref),
                .byte_out (),
                .hit      (cell_hit[k])
            );
        end
    end

    // ------------------------------------------------------------------
    // Region state: fill count, byte position, reported flag
    // ------------------------------------------------------------------
    logic [LEN_BITS-1:0]    fill_reg;
    logic [LEN_BITS-1:0]    fill_next;
    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] pos_next;
    logic                   reported_reg;
    logic                   reported_next;

    logic                   window_full_enough;
    logic                   match;
    logic                   push;
    logic [WIDE_W-1:0]      off_wide;
    result_beat_t           push_beat;

    // fill count after this byte must cover the signature
    assign window_full_enough =
        (LEN_BITS+1)'(fill_reg) + (LEN_BITS+1)'(1) >= (LEN_BITS+1)'(len_used);
    assign match = !reported_reg && window_full_enough && (&cell_hit);
    assign push  = item_fire && (match || (item.last && !reported_reg));

    // start offset = index of this byte - (len - 1), clamped to 32 bits
    assign off_wide = WIDE_W'(pos_reg) - WIDE_W'(len_used) + WIDE_W'(1);

    always_comb
    begin
        push_beat.found = match;
        if (!match)
        begin
            push_beat.match_offset = '0;
        end
        else if (off_wide > WIDE_W'({OFFSET_W{1'b1}}))
        begin
            push_beat.match_offset = '1;
        end
        else
        begin
            push_beat.match_offset = off_wide[OFFSET_W-1:0];
        end
    end

    always_comb
    begin
        fill_next     = fill_reg;
        pos_next      = pos_reg;
        reported_next = reported_reg;
        if (item_fire)
        begin
            if (item.last)
            begin
                fill_next     = '0;
                pos_next      = '0;
                reported_next = 1'b0;
            end
            else
            begin
                if (fill_reg != LEN_BITS'(MAX_PATTERN))
                begin
                    fill_next = fill_reg + LEN_BITS'(1);
                end
                if (pos_reg != '1)
                begin
                    pos_next = pos_reg + OFFSET_BITS'(1);
                end
                reported_next = reported_reg || match;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            pos_reg      <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            pos_reg      <= pos_next;
            reported_reg <= reported_next;
        end
    end

    // ------------------------------------------------------------------
    // Result buffer
    // ------------------------------------------------------------------
    wbps_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_beat (push_beat),
        .out_ready (result_ready),
        .out_valid (result_valid),
        .out_beat  (result),
        .full      (buf_full)
    );

endmodule

`default_nettype wire

[design/wbps_checker.sv]
// ----------------------------------------------------------------------------
// wbps_checker
// Port-level checks for the signature scanner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_checker
    import wbps_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         item_valid,
    input  wire logic         item_ready,
    input  wire logic         result_valid,
    input  wire logic         result_ready,
    input  wire result_beat_t result
);

    // result beat holds while stalled
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat dropped or changed while stalled");

    // no result appears without a byte taken the cycle before
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid && !(item_valid && item_ready) |=> !result_valid)
        else $error("result beat without an accepted byte");

    // the stream stalls only when results back up
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid)
        else $error("item_ready low with no pending result");

    // a not-found beat carries offset zero
    a_miss_offset: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.found |-> result.match_offset == '0)
        else $error("not-found beat with nonzero offset");

    // once the output drains, the stream is open again
    a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |=> item_ready)
        else $error("item_ready stayed low after the output drained");

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

[dv/tb_wildcard_byte_pattern_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wildcard_byte_pattern_scan
// Streams byte regions through the masked signature scanner and checks every
// found / not-found report, in order, against a predictor inside the bench.
// ----------------------------------------------------------------------------

module tb_wildcard_byte_pattern_scan;
    import wbps_pkg::*;

    // Cycles with no beat on either channel before the run is declared hung
    localparam int IDLE_LIMIT     = 4000;
    // Length of the one long result_ready hold-off
    localparam int RX_HOLD_CYCLES = 150;
    // Settle time after the last report
    localparam int DRAIN_CYCLES   = 4;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_BYTES    = 105;

    // ------------------------------------------------------------------------
    // Scoreboard: register copy, scan state and the queue of reports that the
    // block still owes us.
    // ------------------------------------------------------------------------
    class sig_scan_scoreboard;
        logic [CFG_DATA_W-1:0] pat_lo;
        logic [CFG_DATA_W-1:0] pat_hi;
        logic [CARE_W-1:0]     care;
        logic [LENGTH_W-1:0]   len_reg;
        logic [7:0]            window [SIG_BYTES];
        int                    fill_count;
        logic [OFFSET_W-1:0]   byte_pos;
        bit                    reported;
        result_beat_t          pending_reports[$];
        int                    failures;

        function void clear_region();
            foreach (window[k])
                window[k] = '0;
            fill_count = 0;
            byte_pos   = '0;
            reported   = 1'b0;
        endfunction

        function void reset_all();
            pat_lo  = '0;
            pat_hi  = '0;
            care    = CARE_MASK_RESET;
            len_reg = PATTERN_LEN_RESET;
            clear_region();
        endfunction

        function void set_register(logic [REG_INDEX_W-1:0] index,
                                   logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_PATTERN_LOW:  pat_lo  = data;
                REG_PATTERN_HIGH: pat_hi  = data;
                REG_CARE_MASK:    care    = data[CARE_W-1:0];
                REG_PATTERN_LEN:  len_reg = data[LENGTH_W-1:0];
                default: ;
            endcase
        endfunction

        // Length 0 acts as 1, anything past the window acts as a full window
        function int used_length();
            if (len_reg == 0)
                return 1;
            if (len_reg > SIG_BYTES)
                return SIG_BYTES;
            return int'(len_reg);
        endfunction

        function logic [7:0] sig_byte(int j);
            if (j < 8)
                return pat_lo[8*j +: 8];
            return pat_hi[8*(j-8) +: 8];
        endfunction

        // Advance the scan by one accepted byte and queue any report it causes
        function void note_byte(item_beat_t beat);
            int                  eff_len;
            logic [OFFSET_W-1:0] start_pos;
            bit                  hit;
            result_beat_t        rep;
            eff_len   = used_length();
            start_pos = byte_pos;
            for (int k = SIG_BYTES - 1; k > 0; k--)
                window[k] = window[k-1];
            window[0] = beat.data_byte;
            if (fill_count < SIG_BYTES)
                fill_count++;
            if (byte_pos != '1)
                byte_pos++;

            // window[k] is the byte taken k beats ago; signature byte 0 is oldest
            if (!reported && fill_count >= eff_len)
            begin
                hit = 1'b1;
                for (int j = 0; j < eff_len; j++)
                begin
                    if (care[j] && sig_byte(j) !== window[eff_len-1-j])
                        hit = 1'b0;
                end
                if (hit)
                begin
                    rep.found        = 1'b1;
                    rep.match_offset = start_pos - OFFSET_W'(eff_len - 1);
                    pending_reports.push_back(rep);
                    reported = 1'b1;
                end
            end

            // Region end: not-found only if nothing was reported, then rearm
            if (beat.last)
            begin
                if (!reported)
                begin
                    rep.found        = 1'b0;
                    rep.match_offset = '0;
                    pending_reports.push_back(rep);
                end
                clear_region();
            end
        endfunction

        function void check_report(result_beat_t got);
            result_beat_t want;
            if (pending_reports.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected report: expected none, actual found=%0b offset=%0d",
                         $time, got.found, got.match_offset);
                return;
            end
            want = pending_reports.pop_front();
            if (got.found !== want.found)
            begin
                failures++;
                $display("%0t: found mismatch: expected %0b, actual %0b",
                         $time, want.found, got.found);
            end
            if (got.match_offset !== want.match_offset)
            begin
                failures++;
                $display("%0t: match_offset mismatch: expected %0d, actual %0d",
                         $time, want.match_offset, got.match_offset);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [REG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   item_valid;
    logic                   item_ready;
    item_beat_t             item;
    logic                   result_valid;
    logic                   result_ready;
    result_beat_t           result;

    sig_scan_scoreboard scan_sb = new;

    // Idle shaping knobs, changed per phase by the stimulus process
    bit tx_burst;
    bit rx_burst;
    bit rx_hold_req;

    wildcard_byte_pattern_scan u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Driver tasks. Everything changes on the falling edge; handshakes are
    // sampled on the rising edge, so we always see pre-edge values.
    // ------------------------------------------------------------------------

    // One byte beat; a gap of 0 keeps valid high straight into the next beat
    task automatic send_byte(logic [7:0] value, bit last_flag);
        int unsigned gap;
        item_beat_t  beat;
        gap            = tx_burst ? 0 : $urandom_range(0, 10);
        beat.data_byte = value;
        beat.last      = last_flag;
        repeat (gap)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= beat;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        scan_sb.note_byte(beat);
    endtask

    // Stop offering bytes and wait until the block owes us nothing
    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (scan_sb.pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [REG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        scan_sb.set_register(index, data);
    endtask

    // Registers only change with the block idle and every report collected
    task automatic configure(logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] hi,
                             logic [CARE_W-1:0] care_bits, logic [LENGTH_W-1:0] len);
        drain();
        write_reg(REG_PATTERN_LOW,  lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_CARE_MASK,    CFG_DATA_W'(care_bits));
        write_reg(REG_PATTERN_LEN,  CFG_DATA_W'(len));
    endtask

    // One region. Filler is biased toward signature bytes to bait partial
    // matches; most regions carry a planted signature, some with a bad byte.
    task automatic send_region(int rlen, bit noise);
        logic [7:0] region_bytes[$];
        int         eff_len;
        int         start;
        int         bad;
        eff_len = scan_sb.used_length();
        for (int i = 0; i < rlen; i++)
        begin
            if (noise || $urandom_range(0, 1) == 0)
                region_bytes.push_back(8'($urandom_range(0, 255)));
            else
                region_bytes.push_back(scan_sb.sig_byte($urandom_range(0, eff_len - 1)));
        end
        if (!noise && rlen >= eff_len && $urandom_range(0, 3) != 0)
        begin
            start = $urandom_range(0, rlen - eff_len);
            for (int j = 0; j < eff_len; j++)
            begin
                if (scan_sb.care[j])
                    region_bytes[start+j] = scan_sb.sig_byte(j);
                else
                    region_bytes[start+j] = 8'($urandom_range(0, 255));
            end
            if ($urandom_range(0, 6) == 0)
            begin
                bad = $urandom_range(0, eff_len - 1);
                region_bytes[start+bad] = ~region_bytes[start+bad];
            end
        end
        for (int i = 0; i < rlen; i++)
            send_byte(region_bytes[i], i == rlen - 1);
    endtask

    // Regions are mostly short; one in ten may run up to long_max bytes
    task automatic run_phase(int n_bytes, int short_max, int long_max);
        int sent;
        int rlen;
        sent = 0;
        while (sent < n_bytes)
        begin
            if ($urandom_range(0, 9) == 0)
                rlen = $urandom_range(1, long_max);
            else
                rlen = $urandom_range(1, short_max);
            send_region(rlen, $urandom_range(0, 4) == 0);
            sent += rlen;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random ready gaps, plus one long hold-off on request so
    // the output and skid registers fill and item_ready drops.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned gap;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                repeat (RX_HOLD_CYCLES)
                begin
                    @(negedge clk);
                    result_ready <= 1'b0;
                end
            end
            gap = rx_burst ? 0 : $urandom_range(0, 10);
            repeat (gap)
            begin
                @(negedge clk);
                result_ready <= 1'b0;
            end
            @(negedge clk);
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            scan_sb.check_report(result);
        end
    end

    // Watchdog: any beat on either channel resets the count
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: watchdog: no beat for %0d cycles, %0d reports outstanding",
                         $time, IDLE_LIMIT, scan_sb.pending_reports.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [CARE_W-1:0]     care_pick;
        logic [LENGTH_W-1:0]   len_pick;

        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = REG_PATTERN_LOW;
        cfg_data     = '0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        tx_burst     = 1'b0;
        rx_burst     = 1'b0;
        rx_hold_req  = 1'b0;
        scan_sb.reset_all();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset registers: one-byte signature 0x00, must match.
        // Miss, hit at offset 1, a zero after the hit stays silent even on
        // the last byte, then a one-byte region that misses.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);

        // Length 0 behaves as 1. A '?' data byte is just a byte, no wildcard.
        configure(64'h41, 64'h0, '1, 5'd0);
        send_byte(8'h3F, 1'b0);
        send_byte(8'h41, 1'b1);

        // Length above the window clamps to 16, all wildcards: the full
        // window matches exactly on the last byte of a 16-byte region.
        configure(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, '0, 5'd31);
        for (int i = 0; i < SIG_BYTES; i++)
            send_byte(8'($urandom_range(0, 255)), i == SIG_BYTES - 1);

        // Region shorter than the signature: not-found on its only byte
        configure(64'h0201, 64'h0, '1, 5'd2);
        send_byte(8'h01, 1'b1);

        // Random phases; each starts idle with a fresh register set
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            lo        = {$urandom, $urandom};
            hi        = {$urandom, $urandom};
            care_pick = ($urandom_range(0, 2) == 0) ? '1 : CARE_W'($urandom);
            len_pick  = LENGTH_W'($urandom_range(1, SIG_BYTES));
            case (phase)
                0:
                begin
                    lo        = '1;
                    hi        = '1;
                    care_pick = '1;
                    len_pick  = LENGTH_W'(SIG_BYTES);
                end
                1:
                begin
                    lo        = '0;
                    hi        = '0;
                    care_pick = '0;
                    len_pick  = 5'd1;
                end
                2: len_pick = 5'd0;
                3: len_pick = LENGTH_W'($urandom_range(SIG_BYTES + 1, 31));
                4:
                begin
                    care_pick = '1;
                    len_pick  = 5'd1;
                end
                default: ;
            endcase
            tx_burst = (phase % 4 == 1) || (phase == 4);
            rx_burst = (phase % 4 == 2);
            configure(lo, hi, care_pick, len_pick);
            if (phase == 4)
            begin
                // Every one-to-three byte region reports; with the sink held
                // off and bytes back to back, the block must stall its input.
                rx_hold_req = 1'b1;
                run_phase(PHASE_BYTES, 3, 3);
            end
            else
                run_phase(PHASE_BYTES, 24, (phase % 3 == 0) ? 200 : 40);
        end

        tx_burst = 1'b0;
        drain();
        repeat (10) @(posedge clk);
        if (scan_sb.pending_reports.size() != 0)
        begin
            scan_sb.failures++;
            $display("%0t: %0d expected reports never arrived",
                     $time, scan_sb.pending_reports.size());
        end
        if (scan_sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[wildcard_byte_pattern_scan.f]
design/wbps_pkg.sv
design/wbps_cell.sv
design/wbps_out_buf.sv
design/wildcard_byte_pattern_scan.sv
design/wbps_checker.sv
dv/tb_wildcard_byte_pattern_scan.sv
